// ===== design/wfs_pkg.sv =====
// Shared types, constants and helper functions of the wall-follow sequencer.
`default_nettype none

package wfs_pkg;

  // Fixed-point formats of the distance, speed and gain fields.
  localparam int DIST_FRAC_BITS  = 4;
  localparam int SPEED_FRAC_BITS = 12;
  localparam int GAIN_FRAC       = 12;

  localparam int IN_DATA_W       = 96;
  localparam int OUT_DATA_W      = 64;
  localparam int CFG_INDEX_W     = 3;
  localparam int CFG_DATA_W      = 18;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Phase codes.
  localparam logic [2:0] PH_BACK_OFF     = 3'd0;
  localparam logic [2:0] PH_APPROACH     = 3'd1;
  localparam logic [2:0] PH_ALIGN        = 3'd2;
  localparam logic [2:0] PH_FOLLOW       = 3'd3;
  localparam logic [2:0] PH_SMALL_CORNER = 3'd4;
  localparam logic [2:0] PH_BIG_CORNER   = 3'd5;

  // Locate events.
  localparam logic [2:0] EV_NONE         = 3'd0;
  localparam logic [2:0] EV_LOST_WALL    = 3'd1;
  localparam logic [2:0] EV_ORIGIN       = 3'd2;
  localparam logic [2:0] EV_WALL_REACHED = 3'd3;
  localparam logic [2:0] EV_ALIGNED      = 3'd4;
  localparam logic [2:0] EV_SMALL_CORNER = 3'd5;
  localparam logic [2:0] EV_BIG_CORNER   = 3'd6;
  localparam logic [2:0] EV_CORNER_DONE  = 3'd7;

  // Motor commands.
  localparam logic [2:0] CMD_KEEP       = 3'd0;
  localparam logic [2:0] CMD_STOP       = 3'd1;
  localparam logic [2:0] CMD_SET_SPEED  = 3'd2;
  localparam logic [2:0] CMD_SET_TARGET = 3'd3;
  localparam logic [2:0] CMD_ROTATE     = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] CFG_KP          = 3'd0;
  localparam logic [2:0] CFG_KD          = 3'd1;
  localparam logic [2:0] CFG_KI          = 3'd2;
  localparam logic [2:0] CFG_WALL_TARGET = 3'd3;
  localparam logic [2:0] CFG_BASE_SPEED  = 3'd4;
  localparam logic [2:0] CFG_APPROACH    = 3'd5;
  localparam logic [2:0] CFG_ROTATE_TO   = 3'd6;
  localparam logic [2:0] CFG_RUN_TO      = 3'd7;

  // Configuration reset values.
  localparam logic [15:0] KP_RESET          = 16'd205;
  localparam logic [17:0] KD_RESET          = 18'd143360;
  localparam logic [15:0] KI_RESET          = 16'd0;
  localparam logic [10:0] WALL_TARGET_RESET = 11'd72;
  localparam logic [13:0] BASE_SPEED_RESET  = 14'd4096;
  localparam logic [10:0] APPROACH_RESET    = 11'd128;
  localparam logic [15:0] ROTATE_TO_RESET   = 16'd10000;
  localparam logic [15:0] RUN_TO_RESET      = 16'd15000;

  // Distance constants.
  localparam logic [10:0] DIST_NO_RETURN    = 11'(100 << DIST_FRAC_BITS);
  localparam logic [10:0] DIST_FRONT_CLOSE  = 11'(7 << DIST_FRAC_BITS);
  localparam logic [10:0] DIST_ALIGN_FAR    = 11'(10 << DIST_FRAC_BITS);
  localparam logic [10:0] DIST_CORNER_LEFT  = 11'(5 << DIST_FRAC_BITS);
  localparam logic [10:0] DIST_CORNER_FRONT = 11'(9 << DIST_FRAC_BITS);
  localparam logic [10:0] TURN_DIST_RESET   = 11'(9 << (DIST_FRAC_BITS - 1));
  localparam int          DIST_TWO          = 2 << DIST_FRAC_BITS;

  // Speed and angle constants.
  localparam logic signed [15:0] SPEED_ONE        = 16'(1 << SPEED_FRAC_BITS);
  localparam logic signed [15:0] SPEED_HALF       = 16'(1 << (SPEED_FRAC_BITS - 1));
  localparam logic signed [15:0] SMALL_TURN_ANGLE = 16'sd6349;
  localparam logic signed [16:0] BIG_TURN_LIMIT   = -17'sd6144;
  localparam logic [31:0]        BACKOFF_LIMIT_MS = 32'd999;

  // PID terms are rescaled from error*gain units down to speed units.
  localparam int PID_SHIFT = DIST_FRAC_BITS + 1 + GAIN_FRAC - SPEED_FRAC_BITS;
  localparam int PID_ROUND = (1 << PID_SHIFT) - 1;

  // Alignment spin: |d| * 0.7 in speed units.
  localparam int ALIGN_MUL = 7 << SPEED_FRAC_BITS;
  localparam int ALIGN_DEN = 10 << DIST_FRAC_BITS;

  // Big corner arc: (d + 2) * 0.08 and (d + 14) * 0.08.
  localparam int CORNER_MUL   = 8 << SPEED_FRAC_BITS;
  localparam int CORNER_DEN   = 100 << DIST_FRAC_BITS;
  localparam int CORNER_OFF   = (12 << DIST_FRAC_BITS) * CORNER_MUL;
  localparam int CORNER_OFF_Q = CORNER_OFF / CORNER_DEN;
  localparam int CORNER_OFF_R = CORNER_OFF % CORNER_DEN;

  typedef struct packed {
    logic [15:0] kp;
    logic [17:0] kd;
    logic [15:0] ki;
    logic [10:0] wall_target;
    logic [13:0] base_speed;
    logic [10:0] approach_threshold;
    logic [15:0] rotate_timeout_ms;
    logic [15:0] run_timeout_ms;
  } cfg_t;

  // One tick after unpacking and sensor classification.
  typedef struct packed {
    logic [2:0]         phase;
    logic [31:0]        now;
    logic [10:0]        lf;
    logic [10:0]        lb;
    logic               done;
    logic signed [15:0] heading;
    logic               approach_hit;
    logic               front_close;
    logic               lf_lost;
    logic               corner_clear;
    logic               left_far;
  } item_t;

  typedef struct packed {
    logic [2:0]         next_phase;
    logic [2:0]         locate_event;
    logic [2:0]         motor_cmd;
    logic               left_forward;
    logic               right_forward;
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    logic signed [15:0] rotate_angle;
  } result_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
    logic [31:0] remainder;
  } div_rsp_t;

  function automatic logic signed [15:0] sat16(input logic signed [51:0] v);
    if (v > 52'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -52'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] usat16(input logic [31:0] v);
    if (v > 32'd32767) begin
      return 16'sh7FFF;
    end
    return $signed(v[15:0]);
  endfunction

endpackage

`default_nettype wire

// ===== design/wfs_front.sv =====
// Input side: word handshake, unpacking and sensor classification.
`default_nettype none

module wfs_front (
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [wfs_pkg::IN_DATA_W-1:0]  in_tdata,
  input  wire logic [10:0]                    approach_threshold,
  input  wire logic                           q_full,
  output logic                                q_push,
  output wfs_pkg::item_t                      q_item
);
  import wfs_pkg::*;

  logic [10:0] fr;
  logic [10:0] rt;

  assign fr        = in_tdata[45:35];
  assign rt        = in_tdata[56:46];
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_item.phase        = in_tdata[2:0];
    q_item.now          = in_tdata[34:3];
    q_item.lf           = in_tdata[67:57];
    q_item.lb           = in_tdata[78:68];
    q_item.done         = in_tdata[79];
    q_item.heading      = $signed(in_tdata[95:80]);
    q_item.approach_hit = (fr < approach_threshold) || (q_item.lb < approach_threshold) ||
                          (q_item.lf < approach_threshold) || (rt < approach_threshold);
    q_item.front_close  = fr <= DIST_FRONT_CLOSE;
    q_item.lf_lost      = q_item.lf == DIST_NO_RETURN;
    q_item.corner_clear = (q_item.lf < DIST_CORNER_LEFT) || (fr < DIST_CORNER_FRONT);
    q_item.left_far     = (q_item.lb > DIST_ALIGN_FAR) || (q_item.lf > DIST_ALIGN_FAR);
  end

endmodule

`default_nettype wire

// ===== design/wfs_queue.sv =====
// Short queue of classified ticks between the front and the back.
`default_nettype none

module wfs_queue #(
  parameter int DEPTH = wfs_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wfs_pkg::item_t      push_item,
  output logic                full,
  input  wire logic           pop,
  output logic                valid,
  output wfs_pkg::item_t      pop_item
);
  import wfs_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full     = count_r == CNT_W'(DEPTH);
  assign valid    = count_r != '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;
  assign pop_item = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/wfs_div.sv =====
// Shared radix-2 restoring divider, 32 bits unsigned, one quotient bit per cycle.
`default_nettype none

module wfs_div (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wfs_pkg::div_req_t req,
  output wfs_pkg::div_rsp_t rsp
);
  import wfs_pkg::*;

  localparam int STEPS = 32;
  localparam int CNT_W = $clog2(STEPS);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [31:0]      rem_r;
  logic [31:0]      quo_r;
  logic [31:0]      dvs_r;
  logic [32:0]      shifted;
  logic [33:0]      diff;

  assign shifted = {rem_r, quo_r[31]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_r};

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end else if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      if (!diff[33]) begin
        rem_r <= diff[31:0];
        quo_r <= {quo_r[30:0], 1'b1};
      end else begin
        rem_r <= shifted[31:0];
        quo_r <= {quo_r[30:0], 1'b0};
      end
    end else if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
    end
  end

endmodule

`default_nettype wire

// ===== design/wfs_back.sv =====
// Back end: phase sequencer, PID datapath and the registered result word.
`default_nettype none

module wfs_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wfs_pkg::cfg_t        cfg,
  input  wire logic            q_valid,
  input  wfs_pkg::item_t       q_item,
  output logic                 q_pop,
  output wfs_pkg::div_req_t    div_req,
  input  wfs_pkg::div_rsp_t    div_rsp,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output wfs_pkg::result_t     out_result
);
  import wfs_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CALC1 = 3'd1;
  localparam logic [2:0] S_CALC2 = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0] state_r, state_nxt;
  item_t      cur_r;

  // Sequencer state.
  logic               started_r, started_nxt;
  logic               sc_sub_r, sc_sub_nxt;
  logic               bc_sub_r, bc_sub_nxt;
  logic               rot_cw_r, rot_cw_nxt;
  logic [31:0]        start_time_r, start_time_nxt;
  logic [31:0]        last_tick_r, last_tick_nxt;
  logic signed [13:0] prev_err_r, prev_err_nxt;
  logic signed [31:0] integ_r, integ_nxt;
  logic [10:0]        turn_dist_r, turn_dist_nxt;
  logic signed [15:0] turn_head_r, turn_head_nxt;

  // Datapath registers.
  logic signed [13:0] e_r;
  logic [31:0]        dt_r;
  logic signed [29:0] pprod_r;
  logic signed [32:0] dprod_r;
  logic signed [46:0] edt_r;
  logic signed [31:0] integ_new_r;
  logic signed [48:0] iprod_r;

  logic    out_valid_r;
  result_t out_r;

  // First calculation step.
  logic signed [13:0] e_c;
  logic [31:0]        dt_c;
  logic signed [14:0] dd_c;
  logic signed [29:0] pprod_c;
  logic signed [32:0] dprod_c;
  logic signed [46:0] edt_c;

  assign e_c  = $signed({2'b00, cfg.wall_target, 1'b0}) - $signed({3'b000, cur_r.lf})
              - $signed({3'b000, cur_r.lb});
  assign dt_c = cur_r.now - last_tick_r;
  assign dd_c = $signed({e_c[13], e_c}) - $signed({prev_err_r[13], prev_err_r});
  assign pprod_c = e_c * $signed({1'b0, cfg.kp});
  assign dprod_c = dd_c * $signed({1'b0, cfg.kd});
  assign edt_c   = e_c * $signed({1'b0, dt_c});

  // Second step: integral saturation and divider operands.
  logic signed [47:0] integ_sum;
  logic signed [31:0] integ_sat;
  logic signed [32:0] dprod_neg;
  logic [31:0]        dnum_mag;
  logic signed [11:0] d_c;
  logic signed [11:0] d_neg;
  logic [10:0]        ad;
  logic [31:0]        align_num;
  logic [31:0]        corner_num;
  logic               corner_start;

  assign integ_sum = integ_r + edt_r;
  always_comb begin
    if (integ_sum > 48'sd2147483647) begin
      integ_sat = 32'sh7FFFFFFF;
    end else if (integ_sum < -48'sd2147483648) begin
      integ_sat = 32'sh80000000;
    end else begin
      integ_sat = integ_sum[31:0];
    end
  end

  assign dprod_neg  = -dprod_r;
  assign dnum_mag   = dprod_r[32] ? dprod_neg[31:0] : dprod_r[31:0];
  assign d_c        = $signed({1'b0, cur_r.lb}) - $signed({1'b0, cur_r.lf});
  assign d_neg      = -d_c;
  assign ad         = d_c[11] ? d_neg[10:0] : d_c[10:0];
  assign align_num  = {21'b0, ad} * 32'(ALIGN_MUL);
  assign corner_num = ({21'b0, turn_dist_r} + 32'(DIST_TWO)) * 32'(CORNER_MUL);
  assign corner_start = (cur_r.phase == PH_BIG_CORNER) && !bc_sub_r && !started_r;

  always_comb begin
    div_req.start = state_r == S_CALC2;
    if (cur_r.phase == PH_FOLLOW) begin
      div_req.dividend = dnum_mag;
      div_req.divisor  = dt_r;
    end else if (corner_start) begin
      div_req.dividend = corner_num;
      div_req.divisor  = 32'(CORNER_DEN);
    end else begin
      div_req.dividend = align_num;
      div_req.divisor  = 32'(ALIGN_DEN);
    end
  end

  logic signed [48:0] iprod_c;
  assign iprod_c = integ_new_r * $signed({1'b0, cfg.ki});

  // Final step: PID sum and speeds.
  logic signed [29:0] p_adj;
  logic signed [29:0] p_term;
  logic signed [48:0] i_adj;
  logic signed [48:0] i_term;
  logic [31:0]        dq;
  logic signed [32:0] dmag;
  logic signed [32:0] dterm;
  logic signed [49:0] dsp;
  logic signed [51:0] ls_sum;
  logic signed [51:0] rs_sum;
  logic signed [15:0] follow_ls;
  logic signed [15:0] follow_rs;

  assign p_adj  = pprod_r + (pprod_r[29] ? $signed(30'(PID_ROUND)) : 30'sd0);
  assign p_term = p_adj >>> PID_SHIFT;
  assign i_adj  = iprod_r + (iprod_r[48] ? $signed(49'(PID_ROUND)) : 49'sd0);
  assign i_term = i_adj >>> PID_SHIFT;
  assign dq     = div_rsp.quotient >> PID_SHIFT;
  assign dmag   = $signed({1'b0, dq});
  assign dterm  = (dt_r == '0) ? 33'sd0 : (dprod_r[32] ? -dmag : dmag);
  assign dsp    = p_term + dterm + i_term;
  assign ls_sum = $signed({1'b0, cfg.base_speed}) + dsp;
  assign rs_sum = $signed({1'b0, cfg.base_speed}) - dsp;
  assign follow_ls = sat16(ls_sum);
  assign follow_rs = sat16(rs_sum);

  // Big corner arc speeds from one quotient and remainder.
  logic [31:0]        rsum;
  logic signed [15:0] corner_ls;
  logic signed [15:0] corner_rs;

  assign rsum = div_rsp.quotient + 32'(CORNER_OFF_Q)
              + {31'b0, (div_rsp.remainder + 32'(CORNER_OFF_R)) >= 32'(CORNER_DEN)};
  assign corner_ls = usat16(div_rsp.quotient);
  assign corner_rs = usat16(rsum);

  // Timeouts and alignment.
  logic [31:0]        elapsed;
  logic               over_run;
  logic               over_rot;
  logic               over_backoff;
  logic               aligned;
  logic signed [16:0] hdiff;

  assign elapsed      = cur_r.now - start_time_r;
  assign over_run     = elapsed > {16'b0, cfg.run_timeout_ms};
  assign over_rot     = elapsed > {16'b0, cfg.rotate_timeout_ms};
  assign over_backoff = elapsed > BACKOFF_LIMIT_MS;
  assign aligned      = ad <= 11'd1;
  assign hdiff        = $signed({cur_r.heading[15], cur_r.heading})
                      - $signed({turn_head_r[15], turn_head_r});

  function automatic result_t spin_res(input result_t base, input logic pos,
                                       input logic signed [15:0] spd);
    result_t r;
    r               = base;
    r.motor_cmd     = CMD_SET_TARGET;
    r.left_forward  = pos;
    r.right_forward = !pos;
    r.left_speed    = spd;
    r.right_speed   = spd;
    return r;
  endfunction

  function automatic result_t drive_res(input result_t base, input logic fwd,
                                        input logic signed [15:0] ls,
                                        input logic signed [15:0] rs);
    result_t r;
    r               = base;
    r.motor_cmd     = CMD_SET_SPEED;
    r.left_forward  = fwd;
    r.right_forward = fwd;
    r.left_speed    = ls;
    r.right_speed   = rs;
    return r;
  endfunction

  // Result of an alignment check that did not finish.
  result_t align_spin;
  result_t res;

  always_comb begin
    align_spin = '0;
    align_spin.next_phase = cur_r.phase;
    if (cur_r.left_far) begin
      align_spin = spin_res(align_spin, rot_cw_r, SPEED_HALF);
    end else begin
      align_spin = spin_res(align_spin, !d_c[11], usat16(div_rsp.quotient));
    end
  end

  always_comb begin
    res            = '0;
    res.next_phase = cur_r.phase;
    started_nxt    = started_r;
    sc_sub_nxt     = sc_sub_r;
    bc_sub_nxt     = bc_sub_r;
    rot_cw_nxt     = rot_cw_r;
    start_time_nxt = start_time_r;
    last_tick_nxt  = last_tick_r;
    prev_err_nxt   = prev_err_r;
    integ_nxt      = integ_r;
    turn_dist_nxt  = turn_dist_r;
    turn_head_nxt  = turn_head_r;
    case (cur_r.phase)
      PH_BACK_OFF: begin
        if (!started_r) begin
          start_time_nxt   = cur_r.now;
          res              = drive_res(res, 1'b0, SPEED_ONE, SPEED_ONE);
          started_nxt      = 1'b1;
          res.locate_event = EV_LOST_WALL;
        end else if (over_backoff) begin
          res.motor_cmd    = CMD_STOP;
          started_nxt      = 1'b0;
          res.locate_event = EV_ORIGIN;
          res.next_phase   = PH_APPROACH;
        end
      end
      PH_APPROACH: begin
        if (!started_r) begin
          start_time_nxt = cur_r.now;
          res            = drive_res(res, 1'b1, SPEED_ONE, SPEED_ONE);
          started_nxt    = 1'b1;
        end else if (over_run) begin
          started_nxt    = 1'b0;
          res.next_phase = PH_BACK_OFF;
        end else if (cur_r.approach_hit) begin
          res.motor_cmd    = CMD_STOP;
          started_nxt      = 1'b0;
          res.locate_event = EV_WALL_REACHED;
          res.next_phase   = PH_ALIGN;
        end
      end
      PH_ALIGN: begin
        if (!started_r) begin
          start_time_nxt = cur_r.now;
          rot_cw_nxt     = 1'b1;
          res            = spin_res(res, 1'b1, SPEED_HALF);
          started_nxt    = 1'b1;
        end else if (over_rot) begin
          started_nxt    = 1'b0;
          res.next_phase = PH_BACK_OFF;
        end else if (!cur_r.left_far && aligned) begin
          res.motor_cmd    = CMD_STOP;
          started_nxt      = 1'b0;
          res.locate_event = EV_ALIGNED;
          res.next_phase   = PH_FOLLOW;
        end else begin
          res = align_spin;
        end
      end
      PH_FOLLOW: begin
        if (!started_r) begin
          start_time_nxt = cur_r.now;
          prev_err_nxt   = '0;
          integ_nxt      = '0;
          res            = drive_res(res, 1'b1, $signed({2'b00, cfg.base_speed}),
                                     $signed({2'b00, cfg.base_speed}));
          started_nxt    = 1'b1;
        end else if (over_run) begin
          started_nxt    = 1'b0;
          res.next_phase = PH_BACK_OFF;
        end else begin
          last_tick_nxt = cur_r.now;
          integ_nxt     = integ_new_r;
          prev_err_nxt  = e_r;
          if (cur_r.lb != DIST_NO_RETURN) begin
            turn_dist_nxt = cur_r.lb;
          end
          if (cur_r.front_close) begin
            res.motor_cmd    = CMD_STOP;
            started_nxt      = 1'b0;
            res.locate_event = EV_SMALL_CORNER;
            res.next_phase   = PH_SMALL_CORNER;
          end else if (cur_r.lf_lost) begin
            res.motor_cmd    = CMD_STOP;
            started_nxt      = 1'b0;
            res.locate_event = EV_BIG_CORNER;
            res.next_phase   = PH_BIG_CORNER;
          end else begin
            res = spin_res(res, 1'b1, follow_ls);
            res.right_forward = 1'b1;
            res.right_speed   = follow_rs;
          end
        end
      end
      PH_SMALL_CORNER: begin
        if (!sc_sub_r) begin
          if (!started_r) begin
            start_time_nxt   = cur_r.now;
            res.motor_cmd    = CMD_ROTATE;
            res.rotate_angle = SMALL_TURN_ANGLE;
            started_nxt      = 1'b1;
          end else if (over_rot) begin
            started_nxt    = 1'b0;
            res.next_phase = PH_ALIGN;
          end else if (cur_r.done) begin
            res.motor_cmd = CMD_STOP;
            started_nxt   = 1'b0;
            sc_sub_nxt    = 1'b1;
          end
        end else if (!started_r) begin
          start_time_nxt = cur_r.now;
          rot_cw_nxt     = 1'b0;
          res            = spin_res(res, 1'b0, SPEED_HALF);
          started_nxt    = 1'b1;
        end else if (over_rot) begin
          sc_sub_nxt     = 1'b0;
          started_nxt    = 1'b0;
          res.next_phase = PH_BACK_OFF;
        end else if (!cur_r.left_far && aligned) begin
          res.motor_cmd    = CMD_STOP;
          started_nxt      = 1'b0;
          sc_sub_nxt       = 1'b0;
          res.locate_event = EV_CORNER_DONE;
          res.next_phase   = PH_FOLLOW;
        end else begin
          res = align_spin;
        end
      end
      PH_BIG_CORNER: begin
        if (!bc_sub_r) begin
          if (!started_r) begin
            start_time_nxt = cur_r.now;
            res            = drive_res(res, 1'b1, corner_ls, corner_rs);
            turn_head_nxt  = cur_r.heading;
            started_nxt    = 1'b1;
          end else if (over_rot) begin
            started_nxt    = 1'b0;
            res.next_phase = PH_BACK_OFF;
          end else if ((hdiff < BIG_TURN_LIMIT) && cur_r.corner_clear) begin
            res.motor_cmd = CMD_STOP;
            started_nxt   = 1'b0;
            bc_sub_nxt    = 1'b1;
          end
        end else if (!started_r) begin
          start_time_nxt = cur_r.now;
          rot_cw_nxt     = 1'b1;
          res            = spin_res(res, 1'b1, SPEED_HALF);
          started_nxt    = 1'b1;
        end else if (over_rot) begin
          bc_sub_nxt     = 1'b0;
          started_nxt    = 1'b0;
          res.next_phase = PH_BACK_OFF;
        end else if (!cur_r.left_far && aligned) begin
          res.motor_cmd    = CMD_STOP;
          started_nxt      = 1'b0;
          bc_sub_nxt       = 1'b0;
          res.locate_event = EV_CORNER_DONE;
          res.next_phase   = PH_FOLLOW;
        end else begin
          res = align_spin;
        end
      end
      default: begin
        res.next_phase = PH_BACK_OFF;
      end
    endcase
  end

  logic fin_go;
  assign fin_go = (state_r == S_FIN) && (!out_valid_r || out_ready);
  assign q_pop  = (state_r == S_IDLE) && q_valid;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (q_valid) state_nxt = S_CALC1;
      S_CALC1: state_nxt = S_CALC2;
      S_CALC2: state_nxt = S_DIV;
      S_DIV:   if (div_rsp.done) state_nxt = S_FIN;
      S_FIN:   if (fin_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_item;
    end
    if (state_r == S_CALC1) begin
      e_r     <= e_c;
      dt_r    <= dt_c;
      pprod_r <= pprod_c;
      dprod_r <= dprod_c;
      edt_r   <= edt_c;
    end
    if (state_r == S_CALC2) begin
      integ_new_r <= integ_sat;
    end
    if (state_r == S_DIV) begin
      iprod_r <= iprod_c;
    end
    if (fin_go) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      started_r    <= 1'b0;
      sc_sub_r     <= 1'b0;
      bc_sub_r     <= 1'b0;
      rot_cw_r     <= 1'b0;
      start_time_r <= '0;
      last_tick_r  <= '0;
      prev_err_r   <= '0;
      integ_r      <= '0;
      turn_dist_r  <= TURN_DIST_RESET;
      turn_head_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (fin_go) begin
        out_valid_r  <= 1'b1;
        started_r    <= started_nxt;
        sc_sub_r     <= sc_sub_nxt;
        bc_sub_r     <= bc_sub_nxt;
        rot_cw_r     <= rot_cw_nxt;
        start_time_r <= start_time_nxt;
        last_tick_r  <= last_tick_nxt;
        prev_err_r   <= prev_err_nxt;
        integ_r      <= integ_nxt;
        turn_dist_r  <= turn_dist_nxt;
        turn_head_r  <= turn_head_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_r;

endmodule

`default_nettype wire

// ===== design/wall_follow_sequencer.sv =====
// Top level of the wall-follow sequencer: configuration registers and stream ports.
// The back end takes a new word from the queue only after its last result word is registered,
// and the 32-step shared divider in the back end sets the pace of each word.
// The input queue takes further words while the back end works or the output waits.
// Reset: synchronous, active-low rst_n clears the sequencer state, empties the queue
// and returns every configuration register to its default value; no clearing pass.
`default_nettype none

module wall_follow_sequencer #(
  parameter int QUEUE_DEPTH = wfs_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // in_tdata, from bit 0: phase_request[3], now_ms[32], range_front[11],
  // range_right[11], range_left_front[11], range_left_back[11], rotate_done[1],
  // heading[16].
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [wfs_pkg::IN_DATA_W-1:0]    in_tdata,
  // out_tdata, from bit 0: next_phase[3], locate_event[3], motor_cmd[3],
  // left_forward[1], right_forward[1], left_speed[16], right_speed[16],
  // rotate_angle[16], then five zero bits.
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [wfs_pkg::OUT_DATA_W-1:0]        out_tdata,
  input  wire logic                             cfg_wr_en,
  input  wire logic [wfs_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [wfs_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import wfs_pkg::*;

  // Configuration registers. Software must write them only while the block is idle; the
  // block itself does not enforce this, and the back end reads them directly.
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp                 <= KP_RESET;
      cfg_r.kd                 <= KD_RESET;
      cfg_r.ki                 <= KI_RESET;
      cfg_r.wall_target        <= WALL_TARGET_RESET;
      cfg_r.base_speed         <= BASE_SPEED_RESET;
      cfg_r.approach_threshold <= APPROACH_RESET;
      cfg_r.rotate_timeout_ms  <= ROTATE_TO_RESET;
      cfg_r.run_timeout_ms     <= RUN_TO_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_KP:          cfg_r.kp                 <= cfg_wdata[15:0];
        CFG_KD:          cfg_r.kd                 <= cfg_wdata[17:0];
        CFG_KI:          cfg_r.ki                 <= cfg_wdata[15:0];
        CFG_WALL_TARGET: cfg_r.wall_target        <= cfg_wdata[10:0];
        CFG_BASE_SPEED:  cfg_r.base_speed         <= cfg_wdata[13:0];
        CFG_APPROACH:    cfg_r.approach_threshold <= cfg_wdata[10:0];
        CFG_ROTATE_TO:   cfg_r.rotate_timeout_ms  <= cfg_wdata[15:0];
        CFG_RUN_TO:      cfg_r.run_timeout_ms     <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // The front end unpacks each input word and classifies the range readings against the
  // fixed thresholds and the configured approach threshold, then pushes the tick into a short queue.
  logic     q_full;
  logic     q_push;
  item_t    q_in_item;
  logic     q_valid;
  logic     q_pop;
  item_t    q_out_item;

  wfs_front u_front (
    .in_tvalid          (in_tvalid),
    .in_tready          (in_tready),
    .in_tdata           (in_tdata),
    .approach_threshold (cfg_r.approach_threshold),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_item             (q_in_item)
  );

  wfs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_item  (q_out_item)
  );

  // The back end runs the phase sequencer. Every tick goes through the multiply
  // steps and one pass of the shared divider, which serves the
  // derivative quotient, the alignment spin speed and the big corner arc.
  div_req_t div_req;
  div_rsp_t div_rsp;
  result_t  result;

  wfs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  wfs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_item     (q_out_item),
    .q_pop      (q_pop),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (result)
  );

  assign out_tdata = {5'b00000, result.rotate_angle, result.right_speed, result.left_speed,
                      result.right_forward, result.left_forward, result.motor_cmd,
                      result.locate_event, result.next_phase};

endmodule

`default_nettype wire

// ===== design/wfs_checker.sv =====
// Port-level checks on the result stream of the wall-follow sequencer.
`default_nettype none

module wfs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata
);

  // A stalled result word stays in place.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // Reset leaves no stale result on the output.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // The next phase is always one of the six real phases.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] <= 3'd5)
    else $error("next phase out of range");

  // Keep, stop and rotate commands carry no directions or speeds.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[8:6] == 3'd0 || out_tdata[8:6] == 3'd1 ||
                   out_tdata[8:6] == 3'd4) |-> out_tdata[42:9] == '0)
    else $error("speed fields set without a speed command");

  // A rotate angle appears only with the rotate command.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[8:6] != 3'd4 |-> out_tdata[58:43] == '0)
    else $error("rotate angle set without a rotate command");

endmodule

bind wall_follow_sequencer wfs_checker u_wfs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
